@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the k-smallest selection block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, muted while reset is high.
`define ASSERT_CLK(label, clk_sig, rst_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (prop)) \
    else $error(msg);

// Concurrent check that also holds during reset.
`define ASSERT_ALWAYS(label, clk_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) (prop)) else $error(msg);

`endif

@@ src/tksel_pkg.sv @@
// ----------------------------------------------------------------------------
// tksel_pkg
// Types, constants and helpers shared by the k-smallest selection cells.
// ----------------------------------------------------------------------------
package tksel_pkg;

  // Number of cells in the row, which is also the largest usable rank.
  localparam int MAX_RANK = 16;
  // Width of one kept value.
  localparam int DATA_W   = 32;
  // Width of the rank register.
  localparam int RANK_W   = 5;
  // Width of the clamped rank, able to hold MAX_RANK itself.
  localparam int KEFF_W   = $clog2(MAX_RANK + 1);

  // Per-cell control, broadcast to the row each cycle.
  typedef struct packed {
    logic                     step;   // a beat is accepted this cycle
    logic                     clear;  // the beat closes the set
    logic                     en;     // cell index lies below the rank
    logic signed [DATA_W-1:0] item;   // incoming value
  } cell_ctrl_t;

  // What one cell hands to its right-hand neighbor.
  typedef struct packed {
    logic                     valid;  // cell holds a kept value
    logic                     ins;    // new value goes here or further left
    logic signed [DATA_W-1:0] value;
  } cell_link_t;

  // Post-update state of a cell, used to pick the result.
  typedef struct packed {
    logic                     valid_next;
    logic signed [DATA_W-1:0] value_next;
  } cell_view_t;

  // Clamp the programmed rank into 1 .. MAX_RANK.
  function automatic logic [KEFF_W-1:0] eff_rank(input logic [RANK_W-1:0] rank);
    logic [KEFF_W-1:0] k;
    if (rank == '0) begin
      k = KEFF_W'(1);
    end else if (int'(rank) > MAX_RANK) begin
      k = KEFF_W'(MAX_RANK);
    end else begin
      k = KEFF_W'(rank);
    end
    return k;
  endfunction

endpackage

@@ src/tksel_cell.sv @@
// ----------------------------------------------------------------------------
// tksel_cell
// One compare-and-shift cell of the sorted row of kept values.
// ----------------------------------------------------------------------------
module tksel_cell (
  input  logic                  clk,
  input  logic                  rst,
  input  tksel_pkg::cell_ctrl_t ctrl,
  input  tksel_pkg::cell_link_t prev,
  output tksel_pkg::cell_link_t link,
  output tksel_pkg::cell_view_t view
);

  logic                               valid;
  logic signed [tksel_pkg::DATA_W-1:0] value;
  logic                               valid_eff;
  logic                               ins;

  // A cell at or above the rank counts as empty; it is dropped on the next beat.
  assign valid_eff = valid && ctrl.en;
  // The new value lands at the first cell that is empty or holds a larger value.
  assign ins       = !valid_eff || (value > ctrl.item);

  assign link.valid = valid_eff;
  assign link.ins   = ins;
  assign link.value = value;

  // Shift right from the left neighbor, take the new value, or keep.
  always_comb begin
    view.valid_next = ctrl.en && (valid_eff || prev.valid);
    if (prev.ins) begin
      view.value_next = prev.value;
    end else if (ins) begin
      view.value_next = ctrl.item;
    end else begin
      view.value_next = value;
    end
  end

  // Valid bit is control state; the value needs no reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.step) begin
      valid <= view.valid_next && !ctrl.clear;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      value <= view.value_next;
    end
  end

endmodule

@@ src/tksel_row.sv @@
// ----------------------------------------------------------------------------
// tksel_row
// Row of cells holding the k smallest values in ascending order, with the
// selection of the largest kept value at the end of a set.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tksel_row (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                step,
  input  logic                                clear,
  input  logic signed [tksel_pkg::DATA_W-1:0] item,
  input  logic [tksel_pkg::KEFF_W-1:0]        k_eff,
  output logic signed [tksel_pkg::DATA_W-1:0] kth_value,
  output logic                                short_set
);

  tksel_pkg::cell_ctrl_t ctrl [tksel_pkg::MAX_RANK];
  tksel_pkg::cell_link_t link [tksel_pkg::MAX_RANK];
  tksel_pkg::cell_link_t prev [tksel_pkg::MAX_RANK];
  tksel_pkg::cell_view_t view [tksel_pkg::MAX_RANK];
  logic [tksel_pkg::MAX_RANK-1:0] valid_vec;

  // Build the chain: cell 0 sees an always-full left neighbor that never shifts.
  for (genvar i = 0; i < tksel_pkg::MAX_RANK; i++) begin : g_cell
    assign ctrl[i].step  = step;
    assign ctrl[i].clear = clear;
    assign ctrl[i].en    = (tksel_pkg::KEFF_W'(i) < k_eff);
    assign ctrl[i].item  = item;

    if (i == 0) begin : g_head
      assign prev[i].valid = 1'b1;
      assign prev[i].ins   = 1'b0;
      assign prev[i].value = '0;
    end else begin : g_body
      assign prev[i] = link[i-1];
    end

    assign valid_vec[i] = link[i].valid;

    tksel_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .ctrl (ctrl[i]),
      .prev (prev[i]),
      .link (link[i]),
      .view (view[i])
    );
  end

  // The largest kept value sits in the last valid cell after the update.
  // The set is short when the cell at rank k - 1 stays empty.
  always_comb begin
    kth_value = '0;
    short_set = 1'b0;
    for (int j = 0; j < tksel_pkg::MAX_RANK; j++) begin
      if (view[j].valid_next &&
          ((j == tksel_pkg::MAX_RANK - 1) || !view[(j + 1) % tksel_pkg::MAX_RANK].valid_next)) begin
        kth_value = kth_value | view[j].value_next;
      end
      if (tksel_pkg::KEFF_W'(j) == k_eff - 1'b1) begin
        short_set = !view[j].valid_next;
      end
    end
  end

  // Kept cells always form a run starting at cell 0.
  `ASSERT_CLK(a_valid_prefix, clk, rst,
    ((valid_vec & (valid_vec + 1'b1)) == '0), "kept cells are not a contiguous run")
  // Closing a set empties the row.
  `ASSERT_CLK(a_clear_on_last, clk, rst,
    (step && clear |=> valid_vec == '0), "row not empty after the last beat of a set")
  // Any beat inside a set leaves at least one kept value.
  `ASSERT_CLK(a_head_filled, clk, rst,
    (step && !clear |=> valid_vec[0]), "cell 0 empty after a beat inside a set")

endmodule

@@ src/kth_smallest_streaming_topk.sv @@
// ----------------------------------------------------------------------------
// kth_smallest_streaming_topk
// Streaming selection of the kth smallest signed value of each set.
// ----------------------------------------------------------------------------
// The block takes one value beat per clock cycle and keeps the k smallest
// values of the current set in a row of compare-and-shift cells, sorted
// ascending, so each beat is absorbed in the cycle it is accepted. The beat
// flagged with tlast produces one result beat, registered and shown on the
// master side in the next cycle: the kth smallest value, or the largest value
// with tuser set when the set held fewer than k values. Input is held off
// only while an earlier result waits to be taken. The rank is clamped to
// 1 .. 16 and should be written between sets.
`include "assert_macros.svh"

module kth_smallest_streaming_topk (
  input  logic        clk,
  input  logic        rst,
  // Configuration: rank_k
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data,   // [4:0] rank_k
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,    // [31:0] value
  input  logic        s_tlast,    // last_item
  // Result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,    // [31:0] kth_value
  output logic        m_tuser     // [0] short_set
);

  logic [tksel_pkg::RANK_W-1:0]         rank_k;
  logic                                 s_fire;
  logic signed [tksel_pkg::DATA_W-1:0]  row_kth;
  logic                                 row_short;

  // Rank register, writable at any time.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rank_k <= tksel_pkg::RANK_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      rank_k <= cfg_data;
    end
  end

  // Accept a beat whenever the result register is free or being drained.
  assign s_tready = !m_tvalid || m_tready;
  assign s_fire   = s_tvalid && s_tready;

  tksel_row u_row (
    .clk       (clk),
    .rst       (rst),
    .step      (s_fire),
    .clear     (s_tlast),
    .item      (s_tdata),
    .k_eff     (tksel_pkg::eff_rank(rank_k)),
    .kth_value (row_kth),
    .short_set (row_short)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_fire && s_tlast) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire && s_tlast) begin
      m_tdata <= row_kth;
      m_tuser <= row_short;
    end
  end

  // A closing beat always yields a result in the next cycle.
  `ASSERT_CLK(a_result_follows, clk, rst,
    (s_fire && s_tlast |=> m_tvalid), "no result after the last beat of a set")
  // A waiting result is never overwritten.
  `ASSERT_CLK(a_no_overrun, clk, rst,
    (m_tvalid && !m_tready |-> !s_fire), "input accepted while result stalled")
  // Configuration is always taken.
  `ASSERT_ALWAYS(a_cfg_ready, clk, cfg_ready, "configuration port not ready")

endmodule

@@ bench/kth_smallest_streaming_topk_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kth_smallest_streaming_topk_tb
// Self-checking bench for the streaming kth smallest selection block.
// ----------------------------------------------------------------------------
// Sets of signed values are streamed into the block. A clocked driver takes
// them from a queue of pending beats. A clocked monitor compares each result
// beat with the oldest prediction of a bench-side selection model. The rank
// is rewritten between phases, covering its clamped extremes. Both sides of
// the stream idle at random, first the receiver more, then reversed, then not at all.
// A watchdog ends the run when no handshake happens for too long.

module kth_smallest_streaming_topk_tb;

  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 6;
  localparam int PHASE_ITEMS   = 214;
  localparam int N_PHASES      = 9;

  localparam logic signed [tksel_pkg::DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [tksel_pkg::DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    logic signed [tksel_pkg::DATA_W-1:0] value;
    logic                                last;
  } set_beat_t;

  typedef struct packed {
    logic signed [tksel_pkg::DATA_W-1:0] kth;
    logic                                short_flag;
  } kth_result_t;

  logic                         clk       = 1'b0;
  logic                         rst       = 1'b1;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [tksel_pkg::RANK_W-1:0] cfg_data  = '0;
  logic                         s_tvalid  = 1'b0;
  logic                         s_tready;
  logic [31:0]                  s_tdata   = '0;
  logic                         s_tlast   = 1'b0;
  logic                         m_tvalid;
  logic                         m_tready  = 1'b0;
  logic [31:0]                  m_tdata;
  logic                         m_tuser;

  kth_smallest_streaming_topk dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),    // [31:0] value
    .s_tlast  (s_tlast),    // last_item
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),    // [31:0] kth_value
    .m_tuser  (m_tuser)     // [0] short_set
  );

  // Bench-side copy of the selection state and the rank register.
  logic signed [tksel_pkg::DATA_W-1:0] smallest_vals [tksel_pkg::MAX_RANK];
  int                                  smallest_cnt = 0;
  logic [tksel_pkg::RANK_W-1:0]        rank_reg     = tksel_pkg::RANK_W'(1);

  set_beat_t   pending_q  [$];
  kth_result_t kth_queue  [$];
  int          queued_n   = 0;
  int          accepted_n = 0;
  int          mismatches = 0;
  int          send_idle  = 0;
  int          recv_idle  = 0;
  int          stall_cycles = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  // Rank as the block uses it: zero acts as one, large values saturate.
  function automatic int clamp_rank(input logic [tksel_pkg::RANK_W-1:0] r);
    int k;
    k = int'(r);
    if (k == 0) begin
      k = 1;
    end
    if (k > tksel_pkg::MAX_RANK) begin
      k = tksel_pkg::MAX_RANK;
    end
    return k;
  endfunction

  // Position of the largest kept value; needs at least one kept value.
  function automatic int largest_pos();
    int best;
    best = 0;
    for (int i = 1; i < smallest_cnt; i++) begin
      if (smallest_vals[i] > smallest_vals[best]) begin
        best = i;
      end
    end
    return best;
  endfunction

  // Absorb one accepted beat and queue the result it closes, if any.
  function automatic void absorb_beat(input logic signed [tksel_pkg::DATA_W-1:0] v,
                                      input logic last);
    int k;
    int m;
    kth_result_t r;
    k = clamp_rank(rank_reg);
    while (smallest_cnt > k) begin
      m = largest_pos();
      smallest_vals[m] = smallest_vals[smallest_cnt - 1];
      smallest_cnt--;
    end
    if (smallest_cnt < k) begin
      smallest_vals[smallest_cnt] = v;
      smallest_cnt++;
    end else begin
      m = largest_pos();
      // A tie with the largest kept value leaves the store unchanged.
      if (v < smallest_vals[m]) begin
        smallest_vals[m] = v;
      end
    end
    if (last) begin
      m = largest_pos();
      r.kth        = smallest_vals[m];
      r.short_flag = (smallest_cnt < k);
      kth_queue.push_back(r);
      smallest_cnt = 0;
    end
  endfunction

  // Driver: offers pending beats and feeds accepted ones to the model.
  always @(posedge clk) begin
    set_beat_t b;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        absorb_beat(s_tdata, s_tlast);
        accepted_n++;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= send_idle) begin
          b = pending_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= b.value;
          s_tlast  <= b.last;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result beat against the oldest prediction.
  always @(posedge clk) begin
    kth_result_t e;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (kth_queue.size() == 0) begin
          $display("%0t: unexpected result beat, kth_value %0d short_set %0b",
                   $realtime, $signed(m_tdata), m_tuser);
          mismatches++;
        end else begin
          e = kth_queue.pop_front();
          if (m_tdata !== e.kth) begin
            $display("%0t: kth_value mismatch, expected %0d actual %0d",
                     $realtime, e.kth, $signed(m_tdata));
            mismatches++;
          end
          if (m_tuser !== e.short_flag) begin
            $display("%0t: short_set mismatch, expected %0b actual %0b",
                     $realtime, e.short_flag, m_tuser);
            mismatches++;
          end
        end
      end
      m_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if (rst) begin
      stall_cycles <= 0;
    end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic queue_beat(input logic signed [tksel_pkg::DATA_W-1:0] v, input logic last);
    set_beat_t b;
    b.value = v;
    b.last  = last;
    pending_q.push_back(b);
    queued_n++;
  endtask

  // Wait until every beat is taken and every result is back, then settle.
  task automatic wait_drained();
    do begin
      @(posedge clk);
    end while (accepted_n != queued_n || kth_queue.size() != 0 || m_tvalid);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the rank while the block is idle.
  task automatic write_rank(input logic [tksel_pkg::RANK_W-1:0] r);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= r;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    rank_reg = r;
    cfg_valid <= 1'b0;
  endtask

  // Values mix the full range with narrow ranges that force ties and extremes.
  function automatic logic signed [tksel_pkg::DATA_W-1:0] pick_value();
    logic signed [tksel_pkg::DATA_W-1:0] v;
    case ($urandom_range(9))
      5, 6: begin
        v = $signed($urandom_range(15)) - 8;
      end
      7: begin
        case ($urandom_range(3))
          0: v = VAL_MIN;
          1: v = VAL_MAX;
          2: v = '0;
          default: v = -1;
        endcase
      end
      8: begin
        v = VAL_MIN + $signed($urandom_range(7));
      end
      9: begin
        v = VAL_MAX - $signed($urandom_range(7));
      end
      default: begin
        v = $urandom;
      end
    endcase
    return v;
  endfunction

  // Whole sets, mostly sized around the rank, sometimes long.
  task automatic queue_random_sets(input int n_items);
    int k;
    int len;
    int done;
    k    = clamp_rank(rank_reg);
    done = 0;
    while (done < n_items) begin
      if ($urandom_range(7) == 0) begin
        len = $urandom_range(40, 1);
      end else begin
        len = $urandom_range(2 * k + 2, 1);
      end
      for (int i = 0; i < len; i++) begin
        queue_beat(pick_value(), i == len - 1);
      end
      done += len;
    end
  endtask

  // Stimulus sequence: directed sets, then random phases over several ranks.
  initial begin
    logic [tksel_pkg::RANK_W-1:0] phase_rank [N_PHASES];
    phase_rank = '{tksel_pkg::RANK_W'(16), tksel_pkg::RANK_W'(0), tksel_pkg::RANK_W'(31),
                   tksel_pkg::RANK_W'(1), tksel_pkg::RANK_W'(17), tksel_pkg::RANK_W'(2),
                   tksel_pkg::RANK_W'(7), tksel_pkg::RANK_W'(0), tksel_pkg::RANK_W'(16)};
    send_idle = 26;
    recv_idle = 84;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reset rank of one: the set result is its minimum.
    queue_beat(3, 1'b0);
    queue_beat(-7, 1'b1);
    wait_drained();

    write_rank(tksel_pkg::RANK_W'(4));
    // Single value, short of the rank.
    queue_beat(VAL_MAX, 1'b1);
    // Extremes filling the rank exactly.
    queue_beat(VAL_MIN, 1'b0);
    queue_beat(VAL_MAX, 1'b0);
    queue_beat(0, 1'b0);
    queue_beat(-1, 1'b1);
    // Ties with the largest kept value.
    for (int i = 0; i < 5; i++) begin
      queue_beat(5, i == 4);
    end
    // Descending values keep replacing the largest.
    for (int i = 10; i >= 4; i--) begin
      queue_beat(i, i == 4);
    end
    // Ascending values are never kept past the rank.
    for (int i = 1; i <= 5; i++) begin
      queue_beat(i, i == 5);
    end
    wait_drained();

    for (int p = 0; p < N_PHASES; p++) begin
      if (p == 3) begin
        send_idle = 84;
        recv_idle = 26;
      end else if (p == 6) begin
        send_idle = 0;
        recv_idle = 0;
      end
      if (p == 7) begin
        phase_rank[p] = tksel_pkg::RANK_W'($urandom_range(31));
      end
      write_rank(phase_rank[p]);
      queue_random_sets(PHASE_ITEMS);
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ kth_smallest_streaming_topk.f @@
+incdir+src
src/tksel_pkg.sv
src/tksel_cell.sv
src/tksel_row.sv
src/kth_smallest_streaming_topk.sv
bench/kth_smallest_streaming_topk_tb.sv
